// ===== rtl/lbma_pkg.sv =====
// ----------------------------------------------------------------------------
// lbma_pkg
// Shared types and constants of the largest-block memory allocator.
// ----------------------------------------------------------------------------
package lbma_pkg;

   localparam int MAX_REQUESTS_DEF = 1024;
   localparam int ADDR_BITS_DEF    = 32;
   localparam int MEM_SIZE_RESET   = 1024;
   localparam int CMD_IDX_BITS     = 17;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] alloc_size;
      logic [10:0] request_index;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [31:0] address;
   } rsp_type;

   // broadcast update to the free-block cells
   typedef struct packed {
      logic                    restart;
      logic [31:0]             size;
      logic                    wr_en;
      logic [CMD_IDX_BITS-1:0] wr_idx;
      logic                    wr_valid;
      logic [31:0]             wr_start;
      logic [31:0]             wr_len;
      logic                    kill_en;
      logic [CMD_IDX_BITS-1:0] kill_idx;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

endpackage

// ===== rtl/lbma_cell.sv =====
// ----------------------------------------------------------------------------
// lbma_cell
// One free-block entry of the rotating table; passes its entry to its
// neighbor on every scan cycle and takes broadcast updates by index.
// ----------------------------------------------------------------------------
module lbma_cell #(
   parameter int ADDR_BITS = lbma_pkg::ADDR_BITS_DEF,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  lbma_pkg::cmd_type    cmd,
   input  logic                 in_valid,
   input  logic [ADDR_BITS-1:0] in_start,
   input  logic [ADDR_BITS-1:0] in_len,
   output logic                 out_valid,
   output logic [ADDR_BITS-1:0] out_start,
   output logic [ADDR_BITS-1:0] out_len
);
   import lbma_pkg::*;

   localparam logic [ADDR_BITS-1:0]    RST_LEN = ADDR_BITS'(MEM_SIZE_RESET);
   localparam logic [CMD_IDX_BITS-1:0] MY_IDX  = CMD_IDX_BITS'(INDEX);

   logic                 valid_ff;
   logic [ADDR_BITS-1:0] start_ff;
   logic [ADDR_BITS-1:0] len_ff;
   logic                 wr_hit;
   logic                 kill_hit;

   assign wr_hit   = cmd.wr_en && (cmd.wr_idx == MY_IDX);
   assign kill_hit = cmd.kill_en && (cmd.kill_idx == MY_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= (INDEX == 0) && (RST_LEN != '0);
         start_ff <= '0;
         len_ff   <= RST_LEN;
      end else if (cmd.restart) begin
         valid_ff <= (INDEX == 0) && (cmd.size[ADDR_BITS-1:0] != '0);
         start_ff <= '0;
         len_ff   <= cmd.size[ADDR_BITS-1:0];
      end else if (shift) begin
         valid_ff <= in_valid;
         start_ff <= in_start;
         len_ff   <= in_len;
      end else if (wr_hit) begin
         valid_ff <= cmd.wr_valid;
         start_ff <= cmd.wr_start[ADDR_BITS-1:0];
         len_ff   <= cmd.wr_len[ADDR_BITS-1:0];
      end else if (kill_hit) begin
         valid_ff <= 1'b0;
      end
   end

   assign out_valid = valid_ff;
   assign out_start = start_ff;
   assign out_len   = len_ff;

endmodule

// ===== rtl/largest_block_memory_allocator.sv =====
// ----------------------------------------------------------------------------
// largest_block_memory_allocator
// Worst-fit allocator with coalescing of freed spans.
// ----------------------------------------------------------------------------
// Each word runs a scan and then an apply step: the free-block table is a
// ring of MAX_REQUESTS + 1 cells that rotates once past a single compare
// stage, one entry per cycle, then the apply state writes the update. busy
// is high for the whole item; an allocate word gives one result with
// rsp_valid high for a single cycle, a free word gives none.
// The result is not held: the receiver must take it in that cycle.
// Configuration writes are taken only while busy is low and restart the
// allocator at once with the new size.
// ----------------------------------------------------------------------------
module largest_block_memory_allocator #(
   parameter int MAX_REQUESTS = lbma_pkg::MAX_REQUESTS_DEF,
   parameter int ADDR_BITS    = lbma_pkg::ADDR_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  lbma_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output lbma_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);
   import lbma_pkg::*;

   localparam int FD   = MAX_REQUESTS + 1;
   localparam int FW   = $clog2(FD);
   localparam int RW   = $clog2(MAX_REQUESTS);
   localparam int CW   = $clog2(MAX_REQUESTS + 1);
   localparam int AW   = ADDR_BITS;
   localparam int RECW = 1 + 2 * AW;

   state_type state_ff, state_in;

   logic          c_valid [FD];
   logic [AW-1:0] c_start [FD];
   logic [AW-1:0] c_len   [FD];
   logic          shift;
   cmd_type       cmd;

   logic          accept;
   logic          cfg_we;
   logic [CW-1:0] counter_ff;
   logic [CW-1:0] counter_new;
   logic          numbered;
   logic          idx_ok;
   logic [16:0]   idx_minus;

   logic          act_ff;
   logic [31:0]   size_ff;
   logic          numbered_ff;
   logic [RW-1:0] mine_ff;
   logic          idx_ok_ff;
   logic [RW-1:0] rec_ra_ff;
   logic [FW-1:0] step_ff;

   logic          best_found_ff;
   logic [FW-1:0] best_idx_ff;
   logic [AW-1:0] best_start_ff;
   logic [AW-1:0] best_len_ff;
   logic          left_found_ff;
   logic [FW-1:0] left_idx_ff;
   logic [AW-1:0] left_start_ff;
   logic [AW-1:0] left_len_ff;
   logic          right_found_ff;
   logic [FW-1:0] right_idx_ff;
   logic [AW-1:0] right_len_ff;
   logic          slot_found_ff;
   logic [FW-1:0] slot_idx_ff;

   logic [RECW-1:0] rec_mem [MAX_REQUESTS];
   logic [RECW-1:0] rec_rd_ff;
   logic            rec_we;
   logic [RW-1:0]   rec_wa;
   logic [RECW-1:0] rec_wd;
   logic            rec_ok;
   logic [AW-1:0]   rec_start;
   logic [AW-1:0]   rec_len;

   logic          h_valid;
   logic [AW-1:0] h_start;
   logic [AW-1:0] h_len;
   logic          h_best;
   logic          h_left;
   logic          h_right;

   logic          granted;
   logic          free_ok;
   logic [AW-1:0] m_start;
   logic [AW-1:0] m_len;
   logic [FW-1:0] m_slot;

   // ---------------------------------------------------------------- cells
   for (genvar i = 0; i < FD; i++) begin : g_cell
      lbma_cell #(
         .ADDR_BITS (AW),
         .INDEX     (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .cmd       (cmd),
         .in_valid  (c_valid[(i + 1) % FD]),
         .in_start  (c_start[(i + 1) % FD]),
         .in_len    (c_len[(i + 1) % FD]),
         .out_valid (c_valid[i]),
         .out_start (c_start[i]),
         .out_len   (c_len[i])
      );
   end

   // ------------------------------------------------------------ control
   assign accept = start && !busy;
   assign cfg_we = csr_valid && csr_ready;

   assign numbered    = counter_ff < CW'(MAX_REQUESTS);
   assign counter_new = numbered ? counter_ff + CW'(1) : counter_ff;
   assign idx_minus   = 17'(req_data.request_index) - 17'd1;
   assign idx_ok      = (req_data.request_index != '0)
                     && (32'(req_data.request_index) <= 32'(MAX_REQUESTS))
                     && (32'(req_data.request_index) <= 32'(counter_new))
                     && !(numbered && (32'(req_data.request_index) == 32'(counter_new)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SCAN;
         ST_SCAN:  if (step_ff == FW'(FD - 1)) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b1;
      csr_ready = 1'b0;
      shift     = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            csr_ready = 1'b1;
         end
         ST_SCAN:  shift = 1'b1;
         ST_APPLY: rsp_valid = (act_ff == ACT_ALLOC);
         default:  busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         counter_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (cfg_we) begin
            counter_ff <= '0;
         end else if (accept) begin
            counter_ff <= counter_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff      <= req_data.action;
         size_ff     <= req_data.alloc_size;
         numbered_ff <= numbered;
         mine_ff     <= counter_ff[RW-1:0];
         idx_ok_ff   <= idx_ok;
         rec_ra_ff   <= idx_minus[RW-1:0];
      end
   end

   // ---------------------------------------------------------------- scan
   assign h_valid = c_valid[0];
   assign h_start = c_start[0];
   assign h_len   = c_len[0];
   assign h_best  = h_valid && (!best_found_ff || (h_len > best_len_ff)
                 || ((h_len == best_len_ff) && (h_start > best_start_ff)));
   assign h_left  = h_valid
                 && (({1'b0, h_start} + {1'b0, h_len}) == {1'b0, rec_start});
   assign h_right = h_valid
                 && ({1'b0, h_start} == ({1'b0, rec_start} + {1'b0, rec_len}));

   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff        <= '0;
         best_found_ff  <= 1'b0;
         left_found_ff  <= 1'b0;
         right_found_ff <= 1'b0;
         slot_found_ff  <= 1'b0;
      end else if (shift) begin
         step_ff <= step_ff + FW'(1);
         if (h_best) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= step_ff;
            best_start_ff <= h_start;
            best_len_ff   <= h_len;
         end
         if (h_left) begin
            left_found_ff <= 1'b1;
            left_idx_ff   <= step_ff;
            left_start_ff <= h_start;
            left_len_ff   <= h_len;
         end
         if (h_right) begin
            right_found_ff <= 1'b1;
            right_idx_ff   <= step_ff;
            right_len_ff   <= h_len;
         end
         if (!h_valid && !slot_found_ff) begin
            slot_found_ff <= 1'b1;
            slot_idx_ff   <= step_ff;
         end
      end
   end

   // -------------------------------------------------------------- records
   assign rec_ok    = rec_rd_ff[RECW-1];
   assign rec_start = rec_rd_ff[2*AW-1:AW];
   assign rec_len   = rec_rd_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_wa] <= rec_wd;
      end
      if (accept) begin
         rec_rd_ff <= rec_mem[idx_minus[RW-1:0]];
      end
   end

   // --------------------------------------------------------------- apply
   assign granted = numbered_ff && best_found_ff && (size_ff != '0)
                 && (32'(best_len_ff) >= size_ff);
   assign free_ok = idx_ok_ff && rec_ok
                 && (left_found_ff || right_found_ff || slot_found_ff);
   assign m_start = left_found_ff ? left_start_ff : rec_start;
   assign m_len   = rec_len + (left_found_ff ? left_len_ff : '0)
                 + (right_found_ff ? right_len_ff : '0);
   assign m_slot  = left_found_ff ? left_idx_ff
                 : (right_found_ff ? right_idx_ff : slot_idx_ff);

   always_comb begin
      rec_we = 1'b0;
      rec_wa = counter_ff[RW-1:0];
      rec_wd = '0;
      priority if (accept && (req_data.action == ACT_FREE) && numbered) begin
         rec_we = 1'b1;
      end else if ((state_ff == ST_APPLY) && (act_ff == ACT_ALLOC) && numbered_ff) begin
         rec_we = 1'b1;
         rec_wa = mine_ff;
         rec_wd = {granted, best_start_ff, size_ff[AW-1:0]};
      end else if ((state_ff == ST_APPLY) && (act_ff == ACT_FREE) && free_ok) begin
         rec_we = 1'b1;
         rec_wa = rec_ra_ff;
      end else begin
         rec_we = 1'b0;
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.restart = cfg_we;
      cmd.size    = csr_data;
      if (state_ff == ST_APPLY) begin
         if (act_ff == ACT_ALLOC) begin
            cmd.wr_en    = granted;
            cmd.wr_idx   = CMD_IDX_BITS'(best_idx_ff);
            cmd.wr_valid = (32'(best_len_ff) != size_ff);
            cmd.wr_start = 32'(best_start_ff + size_ff[AW-1:0]);
            cmd.wr_len   = 32'(best_len_ff - size_ff[AW-1:0]);
         end else begin
            cmd.wr_en    = free_ok;
            cmd.wr_idx   = CMD_IDX_BITS'(m_slot);
            cmd.wr_valid = 1'b1;
            cmd.wr_start = 32'(m_start);
            cmd.wr_len   = 32'(m_len);
            cmd.kill_en  = free_ok && left_found_ff && right_found_ff;
            cmd.kill_idx = CMD_IDX_BITS'(right_idx_ff);
         end
      end
   end

   always_comb begin
      rsp_data         = '0;
      rsp_data.granted = granted;
      rsp_data.address = granted ? 32'(best_start_ff + AW'(1)) : '0;
   end

endmodule

// ===== rtl/lbma_check.sv =====
// ----------------------------------------------------------------------------
// lbma_check
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module lbma_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input lbma_pkg::rsp_type rsp_data,
   input logic              csr_ready
);
   import lbma_pkg::*;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_in_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy && !csr_ready)
      else $error("result outside an item");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |-> rsp_data.address == '0)
      else $error("failed allocate with nonzero address");

   a_grant_addr : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted |-> rsp_data.address != '0)
      else $error("granted allocate with zero address");

   a_rsp_pulse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

endmodule

bind largest_block_memory_allocator lbma_check u_lbma_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the largest-block memory allocator. A scoreboard predicts the
// worst-fit placement and coalescing of every accepted word and checks each
// result against the oldest expected one. Directed words cover the edge cases;
// random phases at several memory sizes run mostly well-formed alloc/free
// sequences.
// ----------------------------------------------------------------------------
module tb_top;
   import lbma_pkg::*;

   localparam int NREQ       = MAX_REQUESTS_DEF;
   localparam int FDEPTH     = NREQ + 1;
   localparam int ITEM_LAT   = 1030;
   localparam int CYCLE_LIMIT = 5000000;

   class alloc_scoreboard;
      bit [31:0] fstart [FDEPTH];
      bit [31:0] flen   [FDEPTH];
      bit        fval   [FDEPTH];
      bit [31:0] rstart [NREQ];
      bit [31:0] rlen   [NREQ];
      bit        rok    [NREQ];
      int        item_cnt;
      rsp_type   grant_q [$];
      int        errors;

      function void restart(bit [31:0] size);
         for (int i = 0; i < FDEPTH; i++) begin
            fstart[i] = '0;
            flen[i]   = '0;
            fval[i]   = 1'b0;
         end
         for (int i = 0; i < NREQ; i++) begin
            rstart[i] = '0;
            rlen[i]   = '0;
            rok[i]    = 1'b0;
         end
         item_cnt = 0;
         flen[0]  = size;
         fval[0]  = (size != 0);
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function void release_span(int idx);
         bit [32:0] st;
         bit [32:0] ln;
         int left;
         int right;
         int slot;
         left = -1;
         right = -1;
         slot = -1;
         if (idx == 0 || idx > NREQ || idx > item_cnt) return;
         if (!rok[idx-1]) return;
         st = rstart[idx-1];
         ln = rlen[idx-1];
         for (int i = 0; i < FDEPTH; i++) begin
            if (!fval[i]) begin
               if (slot < 0) slot = i;
               continue;
            end
            if ({1'b0, fstart[i]} + flen[i] == st) left = i;
            if ({1'b0, fstart[i]} == st + ln) right = i;
         end
         if (left < 0 && right < 0 && slot < 0) return;
         rok[idx-1] = 1'b0;
         if (left >= 0) begin
            st = fstart[left];
            ln = ln + flen[left];
            fval[left] = 1'b0;
            slot = left;
         end
         if (right >= 0) begin
            ln = ln + flen[right];
            fval[right] = 1'b0;
            if (left < 0) slot = right;
         end
         fstart[slot] = st[31:0];
         flen[slot]   = ln[31:0];
         fval[slot]   = 1'b1;
      endfunction

      function void note_input(req_type r);
         bit      numbered;
         int      mine;
         int      best;
         rsp_type e;
         numbered = item_cnt < NREQ;
         mine = item_cnt;
         best = -1;
         e = '0;
         if (numbered) item_cnt++;
         if (r.action == ACT_FREE) begin
            release_span(int'(r.request_index));
            return;
         end
         if (numbered && r.alloc_size != 0) begin
            for (int i = 0; i < FDEPTH; i++) begin
               if (!fval[i]) continue;
               if (best < 0 || flen[i] > flen[best] ||
                   (flen[i] == flen[best] && fstart[i] > fstart[best]))
                  best = i;
            end
            if (best >= 0 && flen[best] >= r.alloc_size) begin
               rstart[mine] = fstart[best];
               rlen[mine]   = r.alloc_size;
               rok[mine]    = 1'b1;
               e.granted    = 1'b1;
               e.address    = fstart[best] + 32'd1;
               if (flen[best] == r.alloc_size) fval[best] = 1'b0;
               else begin
                  fstart[best] = fstart[best] + r.alloc_size;
                  flen[best]   = flen[best] - r.alloc_size;
               end
            end
         end
         grant_q.push_back(e);
      endfunction

      task check(rsp_type got);
         rsp_type e;
         if (grant_q.size() == 0) begin
            report($sformatf("unexpected result granted=%0d address=%0d",
                             got.granted, got.address));
            return;
         end
         e = grant_q.pop_front();
         if (got.granted !== e.granted)
            report($sformatf("granted %0d, expected %0d", got.granted, e.granted));
         if (got.address !== e.address)
            report($sformatf("address %0d, expected %0d", got.address, e.address));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   req_type     req_data;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   alloc_scoreboard sb;
   int          send_idle;
   bit [31:0]   mem_size;
   int          cycles;

   largest_block_memory_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check(rsp_data);
         if (start && !busy) sb.note_input(req_data);
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send(bit act, bit [31:0] size, bit [10:0] idx);
      req_type r;
      r.action = act;
      r.alloc_size = size;
      r.request_index = idx;
      if ($urandom_range(99) < send_idle) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_size(bit [31:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (sb.grant_q.size() != 0) @(posedge clock);
      repeat (ITEM_LAT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.restart(value);
      mem_size = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_word();
      int          pick;
      int          idx;
      bit [31:0]   size;
      bit [31:0]   cap;
      pick = $urandom_range(99);
      cap = (mem_size / 16 == 0) ? 32'd1 : mem_size / 16;
      if (pick < 55) begin
         if ($urandom_range(19) == 0) size = $urandom;
         else if ($urandom_range(29) == 0) size = 0;
         else size = $urandom_range(cap, 1);
         send(ACT_ALLOC, size, 11'($urandom));
      end else if (pick < 92) begin
         idx = 0;
         for (int t = 0; t < 20 && idx == 0; t++) begin
            if (sb.item_cnt > 0) begin
               idx = $urandom_range(sb.item_cnt, 1);
               if (!sb.rok[idx-1]) idx = 0;
            end
         end
         send(ACT_FREE, $urandom, idx[10:0]);
      end else begin
         send(ACT_FREE, $urandom, 11'($urandom));
      end
   endtask

   initial begin
      sb = new();
      sb.errors = 0;
      sb.restart(MEM_SIZE_RESET);
      mem_size  = MEM_SIZE_RESET;
      send_idle = 28;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset size
      send(ACT_ALLOC, 32'd1, 11'd0);
      send(ACT_ALLOC, 32'd0, 11'd0);
      send(ACT_ALLOC, 32'd1024, 11'd0);
      send(ACT_ALLOC, 32'd1023, 11'd0);
      send(ACT_ALLOC, 32'd1, 11'd0);
      send(ACT_FREE, 32'd0, 11'd1);
      send(ACT_FREE, 32'd0, 11'd0);
      send(ACT_FREE, 32'd0, 11'h7FF);
      send(ACT_FREE, 32'd0, 11'd3);
      send(ACT_FREE, 32'd0, 11'd6);
      send(ACT_FREE, 32'd0, 11'd100);
      send(ACT_FREE, 32'd0, 11'd1);
      send(ACT_FREE, 32'd0, 11'd4);
      send(ACT_ALLOC, 32'hFFFF_FFFF, 11'd0);
      // equal free blocks: highest start wins
      write_size(32'd1024);
      send(ACT_ALLOC, 32'd100, 11'd0);
      send(ACT_ALLOC, 32'd100, 11'd0);
      send(ACT_ALLOC, 32'd100, 11'd0);
      send(ACT_ALLOC, 32'd724, 11'd0);
      send(ACT_FREE, 32'd0, 11'd1);
      send(ACT_FREE, 32'd0, 11'd3);
      send(ACT_ALLOC, 32'd50, 11'd0);
      write_size(32'd0);
      send(ACT_ALLOC, 32'd5, 11'd0);
      write_size(32'd1);
      send(ACT_ALLOC, 32'd1, 11'd0);
      send(ACT_ALLOC, 32'd1, 11'd0);
      write_size(32'hFFFF_FFFF);
      send(ACT_ALLOC, 32'hFFFF_FFFF, 11'd0);
      send(ACT_FREE, 32'd0, 11'd1);

      write_size(32'd4096);
      send_idle = 28;
      repeat (100) random_word();
      write_size(32'hFFFF_FFFF);
      send_idle = 81;
      repeat (100) random_word();
      write_size(32'd1000);
      send_idle = 0;
      repeat (320) random_word();

      start <= 1'b0;
      @(posedge clock);
      while (sb.grant_q.size() != 0) @(posedge clock);
      repeat (ITEM_LAT + 20) @(posedge clock);
      if (sb.grant_q.size() != 0) sb.report("expected results left over");
      if (sb.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// ===== largest_block_memory_allocator.f =====
rtl/lbma_pkg.sv
rtl/lbma_cell.sv
rtl/largest_block_memory_allocator.sv
rtl/lbma_check.sv
test/tb_top.sv
